// ===== sv/fatan_pkg.sv =====
package fatan_pkg;

   localparam int unsigned QueueDepthDefault = 32;
   localparam int unsigned DivBits = 18;

   localparam logic [15:0] CubicCoef  = 16'h3240;
   localparam logic [15:0] LinearCoef = 16'hFB50;
   localparam logic [17:0] PiQuarter  = 18'h0C90F;
   localparam logic [17:0] Pi3Quarter = 18'h25B2F;

   typedef struct packed {
      logic        zero;
      logic        neg_y;
      logic        neg_num;
      logic        second_half;
      logic [32:0] num_mag;
      logic [32:0] den;
   } job_type;

   typedef struct packed {
      logic        zero;
      logic        neg_y;
      logic        neg_r;
      logic        second_half;
      logic [16:0] r_mag;
   } quot_type;

endpackage

// ===== sv/fatan_ram.sv =====
module fatan_ram #(
   parameter int unsigned Width = 8,
   parameter int unsigned Depth = 4
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] wr_addr,
   input  logic [Width-1:0]         wr_data,
   input  logic [$clog2(Depth)-1:0] rd_addr,
   output logic [Width-1:0]         rd_data
);

   logic [Width-1:0] mem_ff [Depth];
   logic [Width-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== sv/fatan_front.sv =====
module fatan_front (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    in_valid,
   input  logic signed [31:0]      y_coord,
   input  logic signed [31:0]      x_coord,
   input  logic                    out_ready,
   output logic                    in_ready,
   output logic                    out_valid,
   output fatan_pkg::job_type      out_job
);

   logic               valid_ff;
   fatan_pkg::job_type job_ff;
   fatan_pkg::job_type job_in;
   logic signed [32:0] ys;
   logic signed [32:0] xs;
   logic signed [32:0] ay;
   logic signed [33:0] num;
   logic        [33:0] den;

   always_comb begin
      ys = {y_coord[31], y_coord};
      xs = {x_coord[31], x_coord};
      ay = y_coord[31] ? -ys : ys;
      if (!x_coord[31]) begin
         num = {xs[32], xs} - {1'b0, ay};
         den = {xs[32], xs} + {1'b0, ay};
      end else begin
         num = {xs[32], xs} + {1'b0, ay};
         den = {1'b0, ay} - {xs[32], xs};
      end
      job_in.zero        = (x_coord == 32'sd0) && (y_coord == 32'sd0);
      job_in.neg_y       = y_coord[31];
      job_in.neg_num     = num[33];
      job_in.second_half = x_coord[31];
      job_in.num_mag     = num[33] ? 33'(-num) : num[32:0];
      job_in.den         = den[32:0];
   end

   assign in_ready = !valid_ff || out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
      if (in_ready && in_valid) begin
         job_ff <= job_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_job   = job_ff;

endmodule

// ===== sv/fatan_div.sv =====
module fatan_div (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    advance,
   input  logic                    in_valid,
   input  fatan_pkg::job_type      in_job,
   output logic                    out_valid,
   output fatan_pkg::quot_type     out_quot
);

   localparam int unsigned N = fatan_pkg::DivBits;

   logic              v_ff   [N+1];
   logic [33:0]       rem_ff [N+1];
   logic [32:0]       den_ff [N+1];
   logic [N-1:0]      q_ff   [N+1];
   logic [3:0]        flag_ff[N+1];

   always_ff @(posedge clock) begin
      if (advance) begin
         rem_ff[0]  <= {1'b0, in_job.num_mag};
         den_ff[0]  <= in_job.den;
         q_ff[0]    <= '0;
         flag_ff[0] <= {in_job.zero, in_job.neg_y, in_job.neg_num, in_job.second_half};
      end
   end

   // first step compares the unshifted numerator, so the quotient is num * 2^17 / den
   for (genvar s = 0; s < N; s++) begin : g_step
      logic [34:0] trial;
      logic [34:0] shifted;
      always_comb begin
         if (s == 0) begin
            shifted = {1'b0, rem_ff[s]};
         end else begin
            shifted = {rem_ff[s], 1'b0};
         end
         trial   = shifted - {2'b0, den_ff[s]};
      end
      always_ff @(posedge clock) begin
         if (advance) begin
            if (!trial[34]) begin
               rem_ff[s+1] <= trial[33:0];
               q_ff[s+1]   <= {q_ff[s][N-2:0], 1'b1};
            end else begin
               rem_ff[s+1] <= shifted[33:0];
               q_ff[s+1]   <= {q_ff[s][N-2:0], 1'b0};
            end
            den_ff[s+1]  <= den_ff[s];
            flag_ff[s+1] <= flag_ff[s];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i <= N; i++) begin
            v_ff[i] <= 1'b0;
         end
      end else if (advance) begin
         v_ff[0] <= in_valid;
         for (int i = 0; i < N; i++) begin
            v_ff[i+1] <= v_ff[i];
         end
      end
   end

   logic [N-1:0] q_round;
   assign q_round = q_ff[N] + {{(N-1){1'b0}}, 1'b1};

   assign out_valid            = v_ff[N];
   assign out_quot.zero        = flag_ff[N][3];
   assign out_quot.neg_y       = flag_ff[N][2];
   assign out_quot.neg_r       = flag_ff[N][1];
   assign out_quot.second_half = flag_ff[N][0];
   assign out_quot.r_mag       = q_round[N-1:1];

endmodule

// ===== sv/fatan_poly.sv =====
module fatan_poly (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    advance,
   input  logic                    in_valid,
   input  fatan_pkg::quot_type     in_quot,
   output logic                    out_valid,
   output logic signed [18:0]      out_angle
);

   logic [2:0]       v_ff;
   logic [3:0]       f1_ff, f2_ff, f3_ff;
   logic [16:0]      r1_ff, r2_ff;
   logic [16:0]      r2sq_ff;
   logic [16:0]      lin3_ff;
   logic [16:0]      r3_ff;
   logic [18:0]      angle_ff;

   logic [33:0] sq_full;
   logic [33:0] cube_full;
   logic [32:0] lin_full;
   logic [32:0] cub_full;
   logic [16:0] cube_m;
   logic [16:0] lin_m;
   logic [16:0] cub_m;
   logic signed [19:0] poly;
   logic signed [19:0] fin;

   always_comb begin
      sq_full   = r1_ff * r1_ff + 34'h8000;
      cube_full = r2sq_ff * r2_ff + 34'h8000;
      lin_full  = r2_ff * fatan_pkg::LinearCoef + 33'h8000;
      cube_m    = cube_full[32:16];
      cub_full  = r3_ff * fatan_pkg::CubicCoef + 33'h8000;
      cub_m     = cub_full[32:16];
      lin_m     = lin3_ff;
      if (f3_ff[1]) begin
         poly = -$signed({3'b0, cub_m}) + $signed({3'b0, lin_m});
      end else begin
         poly = $signed({3'b0, cub_m}) - $signed({3'b0, lin_m});
      end
      poly = poly + $signed({2'b0, f3_ff[0] ? fatan_pkg::Pi3Quarter : fatan_pkg::PiQuarter});
      fin  = f3_ff[2] ? -poly : poly;
      if (f3_ff[3]) begin
         fin = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (advance) begin
         v_ff <= {v_ff[1:0], in_valid};
      end
      if (advance) begin
         f1_ff   <= {in_quot.zero, in_quot.neg_y, in_quot.neg_r, in_quot.second_half};
         r1_ff   <= in_quot.r_mag;
         f2_ff   <= f1_ff;
         r2_ff   <= r1_ff;
         r2sq_ff <= sq_full[32:16];
         f3_ff   <= f2_ff;
         r3_ff   <= cube_m;
         lin3_ff <= lin_full[32:16];
         angle_ff <= fin[18:0];
      end
   end

   logic       v4_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         v4_ff <= 1'b0;
      end else if (advance) begin
         v4_ff <= v_ff[2];
      end
   end

   assign out_valid = v4_ff;
   assign out_angle = angle_ff;

endmodule

// ===== sv/fixed_atan2_cubic_approx_unit.sv =====
// Four-quadrant arctangent of signed Q16.16 (y, x), returning a 19-bit signed Q3.16 angle
// by a cubic polynomial in the ratio r. One pair can be accepted every clock while req_full
// is low. A result passes through one front register, a 19-register restoring divider
// pipeline, four polynomial stages, then the write into a result queue of
// QueueDepth entries, its registered read and a two-entry output buffer. The pipeline never
// stalls; full rises when queued results plus pairs in flight reach QueueDepth - 1 and falls
// back once results are popped. x = y = 0 returns 0.
module fixed_atan2_cubic_approx_unit #(
   parameter int unsigned QueueDepth = fatan_pkg::QueueDepthDefault
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_push,
   output logic               req_full,
   input  logic signed [31:0] req_y_coord,
   input  logic signed [31:0] req_x_coord,
   output logic               rsp_empty,
   input  logic               rsp_pop,
   output logic signed [18:0] rsp_angle
);

   localparam int unsigned AW  = $clog2(QueueDepth);
   localparam int unsigned CW  = $clog2(QueueDepth + 1);

   logic               f_valid;
   logic               f_ready;
   fatan_pkg::job_type f_job;
   logic               d_valid;
   fatan_pkg::quot_type d_quot;
   logic               p_valid;
   logic signed [18:0] p_angle;

   logic [CW-1:0]  count_ff, count_in;
   logic [CW-1:0]  inflight_ff, inflight_in;
   logic [AW-1:0]  wptr_ff, rptr_ff;
   logic [1:0]     oc_ff, oc_in;
   logic [18:0]    hold0_ff, hold0_in;
   logic [18:0]    hold1_ff, hold1_in;
   logic [18:0]    ram_rd;
   logic           rd_pend_ff;
   logic           advance;
   logic           do_pop;
   logic           do_read;
   logic           f_take;

   // pipeline always advances; admission is throttled so queue never overflows
   assign advance = 1'b1;
   assign req_full = (32'(count_ff) + 32'(inflight_ff) + 32'd1) >= 32'(QueueDepth);

   fatan_front u_front (
      .clock, .reset,
      .in_valid (f_take), .y_coord (req_y_coord), .x_coord (req_x_coord),
      .out_ready (1'b1), .in_ready (f_ready), .out_valid (f_valid), .out_job (f_job)
   );

   fatan_div u_div (
      .clock, .reset, .advance,
      .in_valid (f_valid), .in_job (f_job), .out_valid (d_valid), .out_quot (d_quot)
   );

   fatan_poly u_poly (
      .clock, .reset, .advance,
      .in_valid (d_valid), .in_quot (d_quot), .out_valid (p_valid), .out_angle (p_angle)
   );

   assign f_take = req_push && !req_full && f_ready;

   always_comb begin
      inflight_in = inflight_ff;
      if (f_take && !p_valid) begin
         inflight_in = inflight_ff + 1'b1;
      end else if (!f_take && p_valid) begin
         inflight_in = inflight_ff - 1'b1;
      end
   end

   fatan_ram #(.Width(19), .Depth(QueueDepth)) u_queue (
      .clock,
      .wr_en (p_valid), .wr_addr (wptr_ff), .wr_data (p_angle),
      .rd_addr (rptr_ff), .rd_data (ram_rd)
   );

   // read only when the output buffer is sure to have room when the data lands
   assign do_pop  = rsp_pop && (oc_ff != 2'd0);
   assign do_read = (count_ff != '0) &&
                    (({1'b0, oc_ff} + {2'b0, rd_pend_ff}) <= (do_pop ? 3'd2 : 3'd1));

   always_comb begin
      count_in = count_ff;
      if (p_valid && !do_read) begin
         count_in = count_ff + 1'b1;
      end else if (!p_valid && do_read) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_comb begin
      hold0_in = hold0_ff;
      hold1_in = hold1_ff;
      oc_in    = oc_ff;
      if (do_pop) begin
         hold0_in = hold1_ff;
         oc_in    = oc_ff - 2'd1;
      end
      if (rd_pend_ff) begin
         if (oc_in == 2'd0) begin
            hold0_in = ram_rd;
         end else begin
            hold1_in = ram_rd;
         end
         oc_in = oc_in + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         inflight_ff  <= '0;
         wptr_ff      <= '0;
         rptr_ff      <= '0;
         oc_ff        <= '0;
         rd_pend_ff   <= 1'b0;
      end else begin
         count_ff    <= count_in;
         inflight_ff <= inflight_in;
         if (p_valid) begin
            wptr_ff <= (32'(wptr_ff) == QueueDepth - 1) ? '0 : wptr_ff + 1'b1;
         end
         if (do_read) begin
            rptr_ff <= (32'(rptr_ff) == QueueDepth - 1) ? '0 : rptr_ff + 1'b1;
         end
         rd_pend_ff <= do_read;
         oc_ff      <= oc_in;
         hold0_ff   <= hold0_in;
         hold1_ff   <= hold1_in;
      end
   end

   assign rsp_empty = (oc_ff == 2'd0);
   assign rsp_angle = hold0_ff;

endmodule
